// ===== sv/keyed_peer_table_oldest_replace_assert.svh =====
// Assertion macros for the keyed peer table
`ifndef KEYED_PEER_TABLE_OLDEST_REPLACE_ASSERT_SVH
`define KEYED_PEER_TABLE_OLDEST_REPLACE_ASSERT_SVH
`ifndef SYNTHESIS
`define KPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KPT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/kpt_pkg.sv =====
// Shared types and constants for the keyed peer table
`default_nettype none
package kpt_pkg;
  localparam int KEY_W = 160;
  localparam int ADDR_W = 128;
  localparam int LEN_W = 5;
  localparam int TIME_W = 32;
  localparam logic [LEN_W-1:0] MAX_ADDR_BYTES = 5'd16;
  localparam logic [31:0] SECONDS_PER_DAY = 32'd86400;
  localparam logic [31:0] EXPIRY_RESET = 32'd7 * SECONDS_PER_DAY;

  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_REPLACED  = 3'd2,
    ST_SKIPPED   = 3'd3,
    ST_REJECTED  = 3'd4,
    ST_SWEPT     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WRITE, S_SWEEP, S_DONE
  } state_t;

  typedef struct packed {
    logic start_add;    // latch request, clear scan
    logic start_sweep;
    logic scan_step;    // one entry a cycle
    logic write_req;    // write latched request into chosen slot
    logic sweep_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;    // scan done: no read left and no check pending
    logic sweep_last;
  } stat_t;
endpackage
`default_nettype wire

// ===== sv/kpt_if.sv =====
// Valid/ready channel interfaces for the keyed peer table
`default_nettype none
interface kpt_in_if;
  logic         valid;
  logic         ready;
  logic         command;
  logic [63:0]  key_high;
  logic [63:0]  key_middle;
  logic [31:0]  key_low;
  logic [63:0]  address_upper;
  logic [63:0]  address_lower;
  logic [4:0]   address_length;
  logic         capable;
  logic [31:0]  now_seconds;
  modport source (output valid, command, key_high, key_middle, key_low, address_upper,
                  address_lower, address_length, capable, now_seconds, input ready);
  modport sink (input valid, command, key_high, key_middle, key_low, address_upper,
                address_lower, address_length, capable, now_seconds, output ready);
endinterface

interface kpt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] slot;
  logic [8:0] entry_count;
  logic [8:0] removed_count;
  modport source (output valid, status, slot, entry_count, removed_count, input ready);
  modport sink (input valid, status, slot, entry_count, removed_count, output ready);
endinterface
`default_nettype wire

// ===== sv/kpt_ctrl.sv =====
// Controller state machine for the keyed peer table
`default_nettype none
module kpt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic           is_sweep,
  input  wire logic           quick,     // reject, skip, or add with empty scan
  input  wire logic           out_free,  // result register empty or being taken
  input  wire kpt_pkg::stat_t st,
  output kpt_pkg::cmd_t       cmd,
  output logic                busy
);
  import kpt_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (is_sweep) begin
            cmd.start_sweep = 1'b1;
            state_nxt = S_SWEEP;
          end else begin
            cmd.start_add = 1'b1;
            state_nxt = quick ? S_WRITE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          cmd.write_req = 1'b1;
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (st.sweep_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/kpt_dp.sv =====
// Datapath of the keyed peer table: entry memory, scan and compaction
`default_nettype none
module kpt_dp #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire kpt_pkg::cmd_t       cmd,
  output kpt_pkg::stat_t           st,
  kpt_in_if.sink                   in_ch,
  output logic                     quick,
  output logic [2:0]               res_status,
  output logic [7:0]               res_slot,
  output logic [8:0]               res_entry_count,
  output logic [8:0]               res_removed_count,
  input  wire logic [31:0]         expiry_r
);
  import kpt_pkg::*;
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KEY_W + ADDR_W + LEN_W + TIME_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_r;
  logic [CW-1:0] count_r, count_nxt;

  // latched request
  logic [KEY_W-1:0]  key_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LEN_W-1:0]  len_r;
  logic [TIME_W-1:0] now_r;
  logic [2:0]        pre_r;   // reject or skip status
  logic              pre_done_r;

  // scan state
  logic [CW-1:0] rd_idx_r;    // address being read
  logic [CW-1:0] chk_idx_r;   // index of data in rd_r
  logic          chk_v_r;
  logic          match_r;
  logic [IW-1:0] match_idx_r;
  logic [IW-1:0] old_idx_r;
  logic [TIME_W-1:0] old_time_r;
  logic          old_v_r;
  logic [CW-1:0] keep_r;
  logic [CW-1:0] removed_r;
  logic          none_exp_r;
  logic [TIME_W-1:0] thr_r;

  logic bad_len, in_quick;
  assign bad_len = (in_ch.address_length == '0) || (in_ch.address_length > MAX_ADDR_BYTES);
  assign in_quick = bad_len || !in_ch.capable || (count_r == '0);
  assign quick = in_quick;

  logic [KEY_W-1:0]  rd_key;
  logic [TIME_W-1:0] rd_time;
  assign rd_key = rd_r[EW-1 -: KEY_W];
  assign rd_time = rd_r[TIME_W-1:0];

  logic rd_more;
  assign rd_more = (rd_idx_r < count_r);
  assign st.scan_last = !rd_more && !chk_v_r;
  assign st.sweep_last = !rd_more && !chk_v_r;

  logic hit, keep_it;
  assign hit = chk_v_r && (rd_key == key_r) && !match_r;
  assign keep_it = none_exp_r || (rd_time >= thr_r);

  // write port
  logic          we;
  logic [IW-1:0] wa;
  logic [EW-1:0] wd;
  logic [2:0]    wr_status;
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = {key_r, addr_r, len_r, now_r};
    wr_status = pre_r;
    count_nxt = count_r;
    if (cmd.sweep_step && chk_v_r && keep_it) begin
      we = 1'b1;
      wa = keep_r[IW-1:0];
      wd = rd_r;
    end else if (cmd.write_req && !pre_done_r) begin
      we = 1'b1;
      if (match_r) begin
        // matched key equals the latched key
        wr_status = ST_REFRESHED;
        wa = match_idx_r;
      end else if (count_r < DEPTH_C) begin
        wr_status = ST_INSERTED;
        wa = count_r[IW-1:0];
        count_nxt = count_r + 1'b1;
      end else begin
        wr_status = ST_REPLACED;
        wa = old_idx_r;
      end
    end
    if (cmd.sweep_step && st.sweep_last) count_nxt = keep_r;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[rd_idx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      chk_v_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      chk_v_r <= (cmd.scan_step || cmd.sweep_step) && rd_more;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_add || cmd.start_sweep) begin
      key_r <= {in_ch.key_high, in_ch.key_middle, in_ch.key_low};
      addr_r <= {in_ch.address_upper, in_ch.address_lower};
      len_r <= in_ch.address_length;
      now_r <= in_ch.now_seconds;
      pre_done_r <= bad_len || !in_ch.capable;
      pre_r <= bad_len ? ST_REJECTED : ST_SKIPPED;
      rd_idx_r <= '0;
      match_r <= 1'b0;
      old_v_r <= 1'b0;
      keep_r <= '0;
      removed_r <= '0;
      none_exp_r <= expiry_r > in_ch.now_seconds;
      thr_r <= in_ch.now_seconds - expiry_r;
    end else begin
      if ((cmd.scan_step || cmd.sweep_step) && rd_more) rd_idx_r <= rd_idx_r + 1'b1;
      if (cmd.scan_step && chk_v_r) begin
        if (hit) begin
          match_r <= 1'b1;
          match_idx_r <= chk_idx_r[IW-1:0];
        end
        if (!old_v_r || rd_time < old_time_r) begin
          old_v_r <= 1'b1;
          old_time_r <= rd_time;
          old_idx_r <= chk_idx_r[IW-1:0];
        end
      end
      if (cmd.sweep_step && chk_v_r) begin
        if (keep_it) keep_r <= keep_r + 1'b1;
        else removed_r <= removed_r + 1'b1;
      end
    end
    chk_idx_r <= rd_idx_r;
  end

  // result fields, valid in the cycle the controller finishes
  always_comb begin
    res_removed_count = '0;
    res_slot = '0;
    if (cmd.sweep_step || !cmd.write_req) begin
      res_status = ST_SWEPT;
      res_removed_count = 9'(removed_r);
      res_entry_count = 9'(count_r);
    end else begin
      res_status = wr_status;
      res_entry_count = 9'(count_nxt);
      if (!pre_done_r) res_slot = 8'(wa);
    end
  end
endmodule
`default_nettype wire

// ===== sv/keyed_peer_table_oldest_replace.sv =====
// Top level of the keyed peer table with oldest-entry replacement
//
// Keyed peer table: an add scans the occupied slots one a cycle for a key
// match and for the oldest time, then writes one slot; a rejected or skipped
// add, or an add to an empty table, skips the scan, and a rejected or skipped
// add writes no slot. A sweep reads every occupied slot once and writes
// survivors back packed toward slot 0 through the same table memory, one read
// and at most one write a cycle.
// One request is worked on at a time; the result is held in an output
// register, so the next request is taken while it waits. No clearing pass.
`default_nettype none
`include "keyed_peer_table_oldest_replace_assert.svh"
module keyed_peer_table_oldest_replace #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  kpt_in_if.sink           in_ch,
  kpt_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  import kpt_pkg::*;
  cmd_t cmd;
  stat_t st;
  logic busy, quick, out_free, in_fire;
  logic [31:0] expiry_r;
  logic [2:0] res_status;
  logic [7:0] res_slot;
  logic [8:0] res_entry_count, res_removed_count;
  logic out_v_r;

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_free = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) expiry_r <= EXPIRY_RESET;
    else if (cfg_we) expiry_r <= cfg_wdata;
  end

  kpt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .is_sweep(in_ch.command),
    .quick(quick), .out_free(out_free), .st(st), .cmd(cmd), .busy(busy)
  );

  kpt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st), .in_ch(in_ch), .quick(quick),
    .res_status(res_status), .res_slot(res_slot), .res_entry_count(res_entry_count),
    .res_removed_count(res_removed_count), .expiry_r(expiry_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (cmd.finish) out_v_r <= 1'b1;
    else if (out_ch.ready) out_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ch.status <= res_status;
      out_ch.slot <= res_slot;
      out_ch.entry_count <= res_entry_count;
      out_ch.removed_count <= res_removed_count;
    end
  end
  assign out_ch.valid = out_v_r;

  `KPT_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, busy, !in_fire)
  `KPT_ASSERT_IMPL(a_finish_room, clk, rst_n, cmd.finish, out_free)
  `KPT_ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, out_ch.valid)
endmodule
`default_nettype wire
